@@ sv/tcc_pkg.sv @@
// Text console package: sequencer states, command modes, glyph constants,
// result bundle and cell packing helper. No dependencies.
package tcc_pkg;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_FILL,
        ST_DONE
    } tcc_state_t;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_READ  = 2'd3
    } tcc_mode_t;

    localparam logic [7:0] NEWLINE_GLYPH = 8'd10;
    localparam logic [7:0] SPACE_GLYPH   = 8'h20;
    localparam logic [7:0] RESET_COLOR   = 8'h07;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic        scrolled;
    } tcc_result_t;

    function automatic logic [15:0] make_cell(input logic [7:0] glyph,
                                              input logic [7:0] color);
        return {color, glyph};
    endfunction

endpackage

@@ sv/tcc_if.sv @@
// Command and result channel interfaces of the text console.
// Valid/ready handshake; no package dependency.
interface tcc_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] character;
    logic [7:0] cell_color;
    logic [6:0] column;
    logic [4:0] row;

    modport source (output valid, mode, character, cell_color, column, row, input ready);
    modport sink   (input valid, mode, character, cell_color, column, row, output ready);
endinterface

interface tcc_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_value;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic        scrolled;

    modport source (output valid, cell_value, cursor_column, cursor_row, scrolled, input ready);
    modport sink   (input valid, cell_value, cursor_column, cursor_row, scrolled, output ready);
endinterface

@@ sv/text_console_cursor_scroll.sv @@
// Text console top level: color register, result register, sequencer and
// screen store. Depends on tcc_pkg, tcc_if, tcc_screen_ram and tcc_seq.
//
// A COLUMNS x ROWS console of 16-bit cells (color in the high byte, glyph
// in the low byte) held in a single synchronous memory with one write and
// one read port. One beat is taken at a time. A scroll walks the
// store through the memory's single write port (copy of all rows but the
// first, then a blank fill of the bottom row), and a clear walks every
// cell. Each command's result waits in the sequencer while the result
// register is full and not taken. After reset a clearing pass loads
// blank cells with color 7; no command beat is taken during it, while
// text_color writes are accepted at any time. The result register lets
// the next command enter while a result is unread.
module text_console_cursor_scroll #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    tcc_cmd_if.sink    cmd,
    tcc_rsp_if.source  rsp
);
    import tcc_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [7:0]        text_color_reg;
    logic              out_valid_reg;
    tcc_result_t       out_data_reg;
    logic              slot_free;
    logic              push;
    tcc_result_t       res;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_rdata;

    assign slot_free = !out_valid_reg || rsp.ready;

    tcc_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_color (text_color_reg),
        .cmd        (cmd),
        .slot_free  (slot_free),
        .push       (push),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    tcc_screen_ram #(
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                text_color_reg <= cfg_wdata;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.cell_value    = out_data_reg.cell_value;
    assign rsp.cursor_column = out_data_reg.cursor_column;
    assign rsp.cursor_row    = out_data_reg.cursor_row;
    assign rsp.scrolled      = out_data_reg.scrolled;

endmodule

@@ sv/tcc_screen_ram.sv @@
// Screen cell store: one write port, one read port, registered read data.
// No dependencies.
module tcc_screen_ram #(
    parameter int DEPTH  = 2000,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [15:0]       wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [15:0]       rdata
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ sv/tcc_seq.sv @@
// Console sequencer: cursor, command decode, scroll copy and fill sweeps.
// Depends on tcc_pkg and tcc_if; drives the ports of tcc_screen_ram.
module tcc_seq #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    localparam int CELLS  = COLUMNS * ROWS,
    localparam int ADDR_W = $clog2(CELLS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          text_color,
    tcc_cmd_if.sink             cmd,
    input  logic                slot_free,
    output logic                push,
    output tcc_pkg::tcc_result_t res,
    output logic                mem_we,
    output logic [ADDR_W-1:0]   mem_waddr,
    output logic [15:0]         mem_wdata,
    output logic [ADDR_W-1:0]   mem_raddr,
    input  logic [15:0]         mem_rdata
);
    import tcc_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
    localparam logic [6:0]        COL_LAST   = 7'(COLUMNS - 1);
    localparam logic [4:0]        ROW_LAST   = 5'(ROWS - 1);

    tcc_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic              pend_reg, pend_next;
    logic [6:0]        col_reg, col_next;
    logic [4:0]        row_reg, row_next;
    logic [15:0]       value_reg, value_next;
    logic              scrolled_reg, scrolled_next;

    logic              accept;
    tcc_mode_t         mode;
    logic              is_newline;
    logic              wrap;
    logic              scroll_hit;
    logic              in_bounds;
    logic              copy_issue;
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] cur_addr;
    logic [15:0]       blank;

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign accept     = cmd.valid && cmd.ready;
    assign mode       = tcc_mode_t'(cmd.mode);
    assign is_newline = (cmd.character == NEWLINE_GLYPH);
    assign wrap       = is_newline || (col_reg == COL_LAST);
    assign scroll_hit = (mode == MODE_PUT) && wrap && (row_reg == ROW_LAST);
    assign in_bounds  = ({1'b0, cmd.column} < 8'(COLUMNS)) && ({1'b0, cmd.row} < 6'(ROWS));
    assign in_addr    = ADDR_W'(cmd.row) * ROW_STRIDE + ADDR_W'(cmd.column);
    assign cur_addr   = ADDR_W'(row_reg) * ROW_STRIDE + ADDR_W'(col_reg);
    assign copy_issue = (idx_reg != COPY_END);
    assign blank      = make_cell(SPACE_GLYPH, text_color);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (idx_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_PUT:   state_next = scroll_hit ? ST_COPY : ST_DONE;
                        MODE_WRITE: state_next = ST_DONE;
                        MODE_CLEAR: state_next = ST_FILL;
                        MODE_READ:  state_next = in_bounds ? ST_READ : ST_DONE;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ: state_next = ST_DONE;
            ST_COPY:
            begin
                if (!copy_issue)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (idx_reg == LAST_CELL)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next      = idx_reg;
        dst_next      = dst_reg;
        pend_next     = pend_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        value_next    = value_reg;
        scrolled_next = scrolled_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = blank;
        mem_raddr     = idx_reg + ROW_STRIDE;
        push          = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = make_cell(SPACE_GLYPH, RESET_COLOR);
                idx_next  = (idx_reg == LAST_CELL) ? '0 : idx_reg + 1'b1;
            end
            ST_IDLE:
            begin
                mem_raddr = in_addr;
                pend_next = 1'b0;
                if (accept)
                begin
                    idx_next      = '0;
                    value_next    = '0;
                    scrolled_next = scroll_hit;
                    case (mode)
                        MODE_PUT:
                        begin
                            if (!is_newline)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = cur_addr;
                                mem_wdata  = make_cell(cmd.character, text_color);
                                value_next = make_cell(cmd.character, text_color);
                            end
                            if (wrap)
                            begin
                                col_next = '0;
                                if (row_reg != ROW_LAST)
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        MODE_WRITE:
                        begin
                            if (in_bounds)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = in_addr;
                                mem_wdata  = make_cell(cmd.character, cmd.cell_color);
                                value_next = make_cell(cmd.character, cmd.cell_color);
                            end
                        end
                        MODE_CLEAR:
                        begin
                            value_next = blank;
                            col_next   = '0;
                            row_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                value_next = mem_rdata;
            end
            ST_COPY:
            begin
                pend_next = copy_issue;
                if (copy_issue)
                begin
                    idx_next = idx_reg + 1'b1;
                    dst_next = idx_reg;
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = mem_rdata;
                end
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
                if (idx_reg != LAST_CELL)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                push = slot_free;
            end
            default:
            begin
            end
        endcase
    end

    assign res.cell_value    = value_reg;
    assign res.cursor_column = col_reg;
    assign res.cursor_row    = row_reg;
    assign res.scrolled      = scrolled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg      <= dst_next;
        value_reg    <= value_next;
        scrolled_reg <= scrolled_next;
    end

endmodule
